>>> hw/rtl/hvn_pkg.sv
// Shared types, constants and helpers for the heightfield vertex normal block.
// Used by the channel interfaces, the iterative unit and the top level.
`default_nettype none
package hvn_pkg;

  localparam int MAX_ROWS_DEF    = 128;
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int HEIGHT_BITS_DEF = 16;

  localparam int CFG_W      = 8;
  localparam int GRID_RESET = 100;

  localparam int DIFF_W   = 22;          // saturated height difference, +-2^20
  localparam int S_W      = 42;          // dx^2 + dz^2 + 2^24
  localparam int ACC_W    = 21;          // sum of up to six unit components
  localparam int Q_W      = 40;          // sum of squared sums
  localparam int NUM_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int FACES    = 6;
  localparam int TAPS     = 9;
  localparam int FACE_QBITS = 17;
  localparam int OUT_QBITS  = 16;

  localparam logic signed [33:0] DIFF_LIMIT = 34'sd1048576;
  localparam logic [NUM_W-1:0]   ONE_Q12    = 64'd4096;
  localparam logic [14:0]        OUT_ONE    = 15'd16384;

  typedef enum logic [0:0] {
    REG_GRID_ROWS    = 1'b0,
    REG_GRID_COLUMNS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FSEL,
    ST_SQX,
    ST_SQZ,
    ST_FSQ_GO,
    ST_FSQ_W,
    ST_FDIV_GO,
    ST_FDIV_W,
    ST_NSQ,
    ST_NSQRT_GO,
    ST_NSQRT_W,
    ST_NDIV_GO,
    ST_NDIV_W,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       start;
    logic       is_sqrt;
    logic [4:0] qbits;
  } iter_req_t;

  function automatic logic signed [DIFF_W-1:0] sat_diff(input logic signed [33:0] v);
    if (v > DIFF_LIMIT) begin
      return DIFF_W'(DIFF_LIMIT);
    end else if (v < -DIFF_LIMIT) begin
      return DIFF_W'(-DIFF_LIMIT);
    end else begin
      return v[DIFF_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/hvn_if.sv
// Valid/ready channel interfaces for query/load items and normal results.
// Depends on hvn_pkg for default widths.
`default_nettype none
interface hvn_in_if #(parameter int HEIGHT_BITS = hvn_pkg::HEIGHT_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [6:0]                    row;
  logic [6:0]                    column;
  logic signed [HEIGHT_BITS-1:0] height;
  modport source(output valid, operation, row, column, height, input ready);
  modport sink(input valid, operation, row, column, height, output ready);
endinterface

interface hvn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic [14:0]        normal_y;
  logic signed [15:0] normal_z;
  logic               out_of_range;
  modport source(output valid, normal_x, normal_y, normal_z, out_of_range, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, out_of_range, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/heightfield_vertex_normals_top.sv
// Heightfield vertex normals: height grid in one RAM, smooth normals on query.
// A load is written on acceptance. A query outside the grid goes straight to the result step;
// a query in the grid reads the nine neighbours, works each touching face, skips the others, then normalizes.
// One item at a time: after a query, the next item is accepted only once the result register
// has taken the result, so any time the result register stays full holds the input too.
// Reset: grid size returns to 100 x 100, no result pending; heights stay unwritten.
`default_nettype none
module heightfield_vertex_normals_top #(
  parameter int MAX_ROWS    = hvn_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = hvn_pkg::MAX_COLUMNS_DEF,
  parameter int HEIGHT_BITS = hvn_pkg::HEIGHT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  hvn_in_if.sink                          in_if,
  hvn_out_if.source                       out_if,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [hvn_pkg::CFG_W-1:0]  cfg_data
);
  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int HB    = HEIGHT_BITS;
  localparam int DW    = hvn_pkg::DIFF_W;
  localparam int AC    = hvn_pkg::ACC_W;

  // configuration
  logic [hvn_pkg::CFG_W-1:0] grid_rows_r, grid_cols_r;
  logic [15:0] rows_eff, cols_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= hvn_pkg::CFG_W'(hvn_pkg::GRID_RESET);
      grid_cols_r <= hvn_pkg::CFG_W'(hvn_pkg::GRID_RESET);
    end else if (cfg_we) begin
      if (cfg_index == hvn_pkg::REG_GRID_ROWS) begin
        grid_rows_r <= cfg_data;
      end else begin
        grid_cols_r <= cfg_data;
      end
    end
  end

  // clamp the grid size to 2..MAX
  always_comb begin
    rows_eff = 16'(grid_rows_r);
    if (rows_eff < 16'd2) rows_eff = 16'd2;
    if (rows_eff > 16'(MAX_ROWS)) rows_eff = 16'(MAX_ROWS);
    cols_eff = 16'(grid_cols_r);
    if (cols_eff < 16'd2) cols_eff = 16'd2;
    if (cols_eff > 16'(MAX_COLUMNS)) cols_eff = 16'(MAX_COLUMNS);
  end

  hvn_pkg::state_t state_r, state_nxt;

  logic [6:0] i_r, j_r;
  logic [3:0] cnt_r;
  logic [1:0] di_r, dj_r;
  logic [2:0] face_r;
  logic [1:0] comp_r;
  logic signed [HB-1:0] h_r [hvn_pkg::TAPS];
  logic signed [DW-1:0] dx_r, dz_r;
  logic [hvn_pkg::S_W-1:0] s_r;
  logic [hvn_pkg::ROOT_W-1:0] len_r, m_r;
  logic signed [AC-1:0] acc_r [3];
  logic [hvn_pkg::Q_W-1:0] q_r;
  logic signed [15:0] nx_r, nz_r;
  logic [14:0] ny_r;
  logic oor_r;

  logic               out_valid_r;
  logic signed [15:0] out_x_r, out_z_r;
  logic [14:0]        out_y_r;
  logic               out_oor_r;

  // input decode
  logic in_fire, is_query, query_oor, load_in_store;
  assign in_fire       = in_if.valid && in_if.ready;
  assign is_query      = (in_if.operation == hvn_pkg::OP_QUERY);
  assign query_oor     = (16'(in_if.row) >= rows_eff) || (16'(in_if.column) >= cols_eff);
  assign load_in_store = (16'(in_if.row) < 16'(MAX_ROWS)) &&
                         (16'(in_if.column) < 16'(MAX_COLUMNS));

  // height store
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [HB-1:0]   ram_rdata;
  logic [AW+8:0]   waddr_w, raddr_w;
  logic [7:0]      rd_row, rd_col;

  assign waddr_w   = (AW+9)'(in_if.row) * (AW+9)'(MAX_COLUMNS) + (AW+9)'(in_if.column);
  assign ram_waddr = waddr_w[AW-1:0];
  assign ram_we    = in_fire && !is_query && load_in_store;

  // neighbor (di-1, dj-1); a wrapped address only feeds faces that stay unused
  assign rd_row    = 8'(i_r) + 8'(di_r) - 8'd1;
  assign rd_col    = 8'(j_r) + 8'(dj_r) - 8'd1;
  assign raddr_w   = (AW+9)'(rd_row) * (AW+9)'(MAX_COLUMNS) + (AW+9)'(rd_col);
  assign ram_raddr = raddr_w[AW-1:0];

  hvn_ram #(.WIDTH(HB), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_if.height),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // which of the six faces touch the vertex
  logic [hvn_pkg::FACES-1:0] fen;
  logic lo_i, lo_j, hi_i, hi_j;
  assign hi_i = (16'(i_r) + 16'd2 <= rows_eff);
  assign hi_j = (16'(j_r) + 16'd2 <= cols_eff);
  assign lo_i = (i_r != 7'd0);
  assign lo_j = (j_r != 7'd0);
  assign fen  = {lo_i && lo_j, lo_i && hi_j, lo_i && hi_j,
                 hi_i && lo_j, hi_i && lo_j, hi_i && hi_j};

  // face taps: dx = ha - hb, dz = hc - hd over the 3x3 neighborhood
  logic signed [HB-1:0] ha, hb, hc, hd;
  always_comb begin
    case (face_r)
      3'd0: begin ha = h_r[4]; hb = h_r[7]; hc = h_r[4]; hd = h_r[5]; end
      3'd1: begin ha = h_r[3]; hb = h_r[6]; hc = h_r[3]; hd = h_r[4]; end
      3'd2: begin ha = h_r[4]; hb = h_r[7]; hc = h_r[6]; hd = h_r[7]; end
      3'd3: begin ha = h_r[1]; hb = h_r[4]; hc = h_r[1]; hd = h_r[2]; end
      3'd4: begin ha = h_r[2]; hb = h_r[5]; hc = h_r[4]; hd = h_r[5]; end
      default: begin ha = h_r[1]; hb = h_r[4]; hc = h_r[3]; hd = h_r[4]; end
    endcase
  end

  logic signed [HB:0]   dxr, dzr;
  logic signed [33:0]   dxe, dze;
  assign dxr = $signed({ha[HB-1], ha}) - $signed({hb[HB-1], hb});
  assign dzr = $signed({hc[HB-1], hc}) - $signed({hd[HB-1], hd});
  assign dxe = {{(33 - HB){dxr[HB]}}, dxr};
  assign dze = {{(33 - HB){dzr[HB]}}, dzr};

  logic signed [2*DW-1:0] sq_dx, sq_dz;
  assign sq_dx = dx_r * dx_r;
  assign sq_dz = dz_r * dz_r;

  logic signed [AC-1:0]   acc_sel;
  logic signed [2*AC-1:0] sq_acc;
  assign acc_sel = acc_r[comp_r];
  assign sq_acc  = acc_sel * acc_sel;

  // magnitudes for the division numerators
  logic signed [DW-1:0] fc;
  logic [DW-1:0]        fmag;
  logic                 fneg;
  logic [AC-1:0]        amag;
  always_comb begin
    fc   = (comp_r == 2'd0) ? dx_r : dz_r;
    fneg = (comp_r != 2'd1) && fc[DW-1];
    fmag = fc[DW-1] ? DW'(-fc) : DW'(fc);
    amag = acc_sel[AC-1] ? AC'(-acc_sel) : AC'(acc_sel);
  end

  // iterative unit
  hvn_pkg::iter_req_t         req;
  logic [hvn_pkg::NUM_W-1:0]  it_num;
  logic [hvn_pkg::ROOT_W-1:0] it_den;
  logic                       it_done;
  logic [hvn_pkg::ROOT_W-1:0] it_res;

  hvn_iter u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .num    (it_num),
    .den    (it_den),
    .done   (it_done),
    .result (it_res)
  );

  always_comb begin
    req    = '0;
    it_num = '0;
    it_den = len_r;
    case (state_r)
      hvn_pkg::ST_FSQ_GO: begin
        req.start = 1'b1; req.is_sqrt = 1'b1;
        it_num = hvn_pkg::NUM_W'(s_r) << 20;
      end
      hvn_pkg::ST_FDIV_GO: begin
        req.start = 1'b1; req.qbits = 5'(hvn_pkg::FACE_QBITS);
        it_num = ((comp_r == 2'd1) ? (hvn_pkg::ONE_Q12 << 26)
                                   : (hvn_pkg::NUM_W'(fmag) << 26))
                 + hvn_pkg::NUM_W'(len_r >> 1);
      end
      hvn_pkg::ST_NSQRT_GO: begin
        req.start = 1'b1; req.is_sqrt = 1'b1;
        it_num = hvn_pkg::NUM_W'(q_r) << 20;
      end
      hvn_pkg::ST_NDIV_GO: begin
        req.start = 1'b1; req.qbits = 5'(hvn_pkg::OUT_QBITS);
        it_den = m_r;
        it_num = (hvn_pkg::NUM_W'(amag) << 24) + hvn_pkg::NUM_W'(m_r >> 1);
      end
      default: ;
    endcase
  end

  // output saturation of the current component
  logic [14:0]        omag;
  logic signed [15:0] osgn;
  assign omag = (it_res[15:0] > 16'(hvn_pkg::OUT_ONE)) ? hvn_pkg::OUT_ONE : it_res[14:0];
  assign osgn = acc_sel[AC-1] ? -$signed({1'b0, omag}) : $signed({1'b0, omag});

  logic signed [AC-1:0] fq;
  assign fq = $signed({{(AC - hvn_pkg::FACE_QBITS){1'b0}}, it_res[hvn_pkg::FACE_QBITS-1:0]});

  logic out_free;
  assign out_free = !out_valid_r || out_if.ready;

  // next state
  always_comb begin
    state_nxt   = state_r;
    in_if.ready = 1'b0;
    unique case (state_r)
      hvn_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid && is_query) begin
          state_nxt = query_oor ? hvn_pkg::ST_DONE : hvn_pkg::ST_READ;
        end
      end
      hvn_pkg::ST_READ:
        if (cnt_r == 4'(hvn_pkg::TAPS)) state_nxt = hvn_pkg::ST_FSEL;
      hvn_pkg::ST_FSEL:
        if (fen[face_r]) state_nxt = hvn_pkg::ST_SQX;
        else if (face_r == 3'(hvn_pkg::FACES - 1)) state_nxt = hvn_pkg::ST_NSQ;
      hvn_pkg::ST_SQX:     state_nxt = hvn_pkg::ST_SQZ;
      hvn_pkg::ST_SQZ:     state_nxt = hvn_pkg::ST_FSQ_GO;
      hvn_pkg::ST_FSQ_GO:  state_nxt = hvn_pkg::ST_FSQ_W;
      hvn_pkg::ST_FSQ_W:   if (it_done) state_nxt = hvn_pkg::ST_FDIV_GO;
      hvn_pkg::ST_FDIV_GO: state_nxt = hvn_pkg::ST_FDIV_W;
      hvn_pkg::ST_FDIV_W:
        if (it_done) begin
          if (comp_r != 2'd2) state_nxt = hvn_pkg::ST_FDIV_GO;
          else if (face_r == 3'(hvn_pkg::FACES - 1)) state_nxt = hvn_pkg::ST_NSQ;
          else state_nxt = hvn_pkg::ST_FSEL;
        end
      hvn_pkg::ST_NSQ:      if (comp_r == 2'd2) state_nxt = hvn_pkg::ST_NSQRT_GO;
      hvn_pkg::ST_NSQRT_GO: state_nxt = hvn_pkg::ST_NSQRT_W;
      hvn_pkg::ST_NSQRT_W:
        if (it_done) state_nxt = (it_res == '0) ? hvn_pkg::ST_DONE : hvn_pkg::ST_NDIV_GO;
      hvn_pkg::ST_NDIV_GO:  state_nxt = hvn_pkg::ST_NDIV_W;
      hvn_pkg::ST_NDIV_W:
        if (it_done) state_nxt = (comp_r == 2'd2) ? hvn_pkg::ST_DONE : hvn_pkg::ST_NDIV_GO;
      hvn_pkg::ST_DONE:     if (out_free) state_nxt = hvn_pkg::ST_IDLE;
      default:              state_nxt = hvn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hvn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      hvn_pkg::ST_IDLE: begin
        i_r    <= in_if.row;
        j_r    <= in_if.column;
        cnt_r  <= '0;
        di_r   <= '0;
        dj_r   <= '0;
        face_r <= '0;
        comp_r <= '0;
        oor_r  <= query_oor;
        nx_r   <= '0;
        ny_r   <= '0;
        nz_r   <= '0;
        for (int k = 0; k < 3; k++) acc_r[k] <= '0;
      end
      hvn_pkg::ST_READ: begin
        // issue one address a cycle, take the data in the next cycle from the registered read
        cnt_r <= cnt_r + 4'd1;
        if (dj_r == 2'd2) begin
          dj_r <= '0;
          di_r <= di_r + 2'd1;
        end else begin
          dj_r <= dj_r + 2'd1;
        end
        for (int k = 0; k < hvn_pkg::TAPS; k++) begin
          if (cnt_r == 4'(k + 1)) h_r[k] <= $signed(ram_rdata);
        end
      end
      hvn_pkg::ST_FSEL: begin
        comp_r <= '0;
        dx_r   <= hvn_pkg::sat_diff(dxe);
        dz_r   <= hvn_pkg::sat_diff(dze);
        if (!fen[face_r]) face_r <= face_r + 3'd1;
      end
      hvn_pkg::ST_SQX: s_r <= sq_dx[hvn_pkg::S_W-1:0];
      hvn_pkg::ST_SQZ: s_r <= s_r + sq_dz[hvn_pkg::S_W-1:0] + (hvn_pkg::S_W'(1) << 24);
      hvn_pkg::ST_FSQ_W: if (it_done) len_r <= it_res;
      hvn_pkg::ST_FDIV_W:
        if (it_done) begin
          for (int k = 0; k < 3; k++) begin
            if (comp_r == 2'(k)) acc_r[k] <= acc_r[k] + (fneg ? -fq : fq);
          end
          if (comp_r == 2'd2) begin
            comp_r <= '0;
            face_r <= face_r + 3'd1;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
      hvn_pkg::ST_NSQ: begin
        // sum the squares of the three sums
        if (comp_r == 2'd0) q_r <= hvn_pkg::Q_W'(sq_acc);
        else q_r <= q_r + hvn_pkg::Q_W'(sq_acc);
        comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
      end
      hvn_pkg::ST_NSQRT_W:
        if (it_done) begin
          m_r <= it_res;
          if (it_res == '0) ny_r <= hvn_pkg::OUT_ONE;
        end
      hvn_pkg::ST_NDIV_W:
        if (it_done) begin
          case (comp_r)
            2'd0:    nx_r <= osgn;
            2'd1:    ny_r <= acc_sel[AC-1] ? 15'd0 : omag;
            default: nz_r <= osgn;
          endcase
          comp_r <= comp_r + 2'd1;
        end
      default: ;
    endcase
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == hvn_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
      out_x_r     <= nx_r;
      out_y_r     <= ny_r;
      out_z_r     <= nz_r;
      out_oor_r   <= oor_r;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.normal_x     = out_x_r;
  assign out_if.normal_y     = out_y_r;
  assign out_if.normal_z     = out_z_r;
  assign out_if.out_of_range = out_oor_r;

endmodule
`default_nettype wire

>>> hw/rtl/hvn_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module hvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/hvn_iter.sv
// Shared bit-serial unit: integer square root or restoring division.
// Depends on hvn_pkg for widths and the request struct.
`default_nettype none
module hvn_iter (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire hvn_pkg::iter_req_t        req,
  input  wire logic [hvn_pkg::NUM_W-1:0] num,
  input  wire logic [hvn_pkg::ROOT_W-1:0] den,
  output logic                           done,
  output logic [hvn_pkg::ROOT_W-1:0]     result
);
  localparam int W = hvn_pkg::NUM_W;

  logic [W-1:0] a_r, b_r, c_r;
  logic [5:0]   cnt_r;
  logic         busy_r, sqrt_r, done_r;
  logic [W-1:0] t;

  assign t      = b_r + c_r;
  assign done   = done_r;
  assign result = b_r[hvn_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        sqrt_r <= req.is_sqrt;
        a_r    <= num;
        b_r    <= '0;
        if (req.is_sqrt) begin
          c_r   <= W'(1) << (W - 2);
          cnt_r <= 6'(W / 2);
        end else begin
          c_r   <= {{(W - hvn_pkg::ROOT_W){1'b0}}, den} << (req.qbits - 5'd1);
          cnt_r <= {1'b0, req.qbits};
        end
      end else if (busy_r) begin
        if (sqrt_r) begin
          if (a_r >= t) begin
            a_r <= a_r - t;
            b_r <= (b_r >> 1) + c_r;
          end else begin
            b_r <= b_r >> 1;
          end
          c_r <= c_r >> 2;
        end else begin
          if (a_r >= c_r) begin
            a_r <= a_r - c_r;
            b_r <= {b_r[W-2:0], 1'b1};
          end else begin
            b_r <= {b_r[W-2:0], 1'b0};
          end
          c_r <= c_r >> 1;
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> tb/heightfield_vertex_normals_top_tb.sv
// Self-checking testbench for heightfield_vertex_normals_top: loads heights, queries
// smooth vertex normals and checks each result against an in-bench fixed-point predictor.
// Depends on hvn_pkg, the hvn_in_if/hvn_out_if interfaces and the top-level RTL.
`default_nettype none
module heightfield_vertex_normals_top_tb;

  localparam int NROW       = 128;
  localparam int NCOL       = 128;
  localparam int DEPTH      = NROW * NCOL;
  localparam int DRAIN_WAIT = 300;        // quiet cycles before a register write and at the end
  localparam longint LIMIT  = 6000000;

  typedef struct packed {
    logic signed [15:0] nx;
    logic [14:0]        ny;
    logic signed [15:0] nz;
    logic               oor;
  } normal_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [hvn_pkg::CFG_W-1:0] cfg_data;

  hvn_in_if #(.HEIGHT_BITS(hvn_pkg::HEIGHT_BITS_DEF)) in_ch();
  hvn_out_if out_ch();

  heightfield_vertex_normals_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the block's state and configuration.
  logic signed [15:0] shadow_h [DEPTH];
  bit                 loaded   [DEPTH];
  int                 rows_cfg;
  int                 cols_cfg;

  normal_t pending_normals[$];
  int      fails;
  int      n_loads, n_queries, n_oor, n_checked;
  longint  cycles;
  bit      quiet;                   // no idling on either side when set
  int      hold_left;               // long receiver hold-off, counted by the receiver

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort the run if it exceeds a generous cycle budget.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_normals.size());
      $display("heightfield_vertex_normals_top_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Round to nearest, ties away from zero.
  function automatic longint div_round(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    if (den == 0) return 0;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint height_at(int x, int z);
    if (x < 0 || z < 0 || x >= NROW || z >= NCOL) return 0;
    return longint'(shadow_h[x * NCOL + z]);
  endfunction

  function automatic void accumulate_face(longint dx, longint dz,
                                          inout longint sx, inout longint sy,
                                          inout longint sz);
    longint unsigned s;
    longint unsigned len;
    dx  = clamp(dx, -(64'sd1 << 20), 64'sd1 << 20);
    dz  = clamp(dz, -(64'sd1 << 20), 64'sd1 << 20);
    s   = longint'(dx * dx) + longint'(dz * dz) + (64'd1 << 24);
    len = int_sqrt(s << 20);
    sx += div_round(dx * (64'sd1 << 26), len);
    sy += div_round(64'sd4096 * (64'sd1 << 26), len);
    sz += div_round(dz * (64'sd1 << 26), len);
  endfunction

  // Upper-left triangle of quad (x,z) and lower-right triangle of the same quad.
  function automatic void face_upper(int x, int z, inout longint sx, inout longint sy,
                                     inout longint sz);
    longint tl;
    tl = height_at(x, z);
    accumulate_face(tl - height_at(x + 1, z), tl - height_at(x, z + 1), sx, sy, sz);
  endfunction

  function automatic void face_lower(int x, int z, inout longint sx, inout longint sy,
                                     inout longint sz);
    longint br;
    br = height_at(x + 1, z + 1);
    accumulate_face(height_at(x, z + 1) - br, height_at(x + 1, z) - br, sx, sy, sz);
  endfunction

  function automatic normal_t predict_normal(int i, int j);
    int rows;
    int cols;
    longint sx, sy, sz;
    longint unsigned q;
    longint unsigned m;
    normal_t r;
    rows = (rows_cfg < 2) ? 2 : ((rows_cfg > NROW) ? NROW : rows_cfg);
    cols = (cols_cfg < 2) ? 2 : ((cols_cfg > NCOL) ? NCOL : cols_cfg);
    r = '0;
    if (i >= rows || j >= cols) begin
      r.oor = 1'b1;
      return r;
    end
    sx = 0; sy = 0; sz = 0;
    if (i + 2 <= rows && j + 2 <= cols) face_upper(i, j, sx, sy, sz);
    if (i + 2 <= rows && j >= 1) begin
      face_upper(i, j - 1, sx, sy, sz);
      face_lower(i, j - 1, sx, sy, sz);
    end
    if (i >= 1 && j + 2 <= cols) begin
      face_upper(i - 1, j, sx, sy, sz);
      face_lower(i - 1, j, sx, sy, sz);
    end
    if (i >= 1 && j >= 1) face_lower(i - 1, j - 1, sx, sy, sz);
    q = longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz);
    m = int_sqrt(q << 20);
    if (m == 0) begin
      r.ny = 15'd16384;
    end else begin
      r.nx = 16'(clamp(div_round(sx * (64'sd1 << 24), m), -16384, 16384));
      r.ny = 15'(clamp(div_round(sy * (64'sd1 << 24), m), 0, 16384));
      r.nz = 16'(clamp(div_round(sz * (64'sd1 << 24), m), -16384, 16384));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 8);
      in_ch.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Drive one transaction at the falling edge and hold it until it is taken.
  // Valid stays high afterwards so back-to-back items need no reassertion.
  task automatic send_item(hvn_pkg::op_t op, int r, int c, logic signed [15:0] h);
    normal_t exp_n;
    sender_gap();
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.row       = 7'(r);
    in_ch.column    = 7'(c);
    in_ch.height    = h;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    if (op == hvn_pkg::OP_LOAD) begin
      shadow_h[r * NCOL + c] = h;
      loaded[r * NCOL + c]   = 1'b1;
      n_loads++;
    end else begin
      exp_n = predict_normal(r, c);
      pending_normals.insert(pending_normals.size(), exp_n);
      n_queries++;
      if (exp_n.oor) n_oor++;
    end
    @(negedge clk);
  endtask

  task automatic release_input();
    in_ch.valid = 1'b0;
  endtask

  // Load random heights into any neighbour of (r,c) not yet written, then query.
  task automatic query_vertex(int r, int c);
    int x, z;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        x = r + dr;
        z = c + dc;
        if (x >= 0 && z >= 0 && x < NROW && z < NCOL && !loaded[x * NCOL + z])
          send_item(hvn_pkg::OP_LOAD, x, z, 16'($urandom));
      end
    end
    send_item(hvn_pkg::OP_QUERY, r, c, 16'($urandom));
  endtask

  task automatic wait_drained();
    release_input();
    while (pending_normals.size() != 0) @(negedge clk);
  endtask

  // Write a register only while idle: drain results, then let a trailing load settle.
  task automatic write_reg(hvn_pkg::cfg_reg_t idx, int value);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = hvn_pkg::CFG_W'(value);
    @(negedge clk);
    cfg_we    = 1'b0;
    if (idx == hvn_pkg::REG_GRID_ROWS) rows_cfg = value;
    else cols_cfg = value;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready bursts plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int burst;
    burst = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ch.ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    normal_t got;
    normal_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.normal_x, out_ch.normal_y, out_ch.normal_z, out_ch.out_of_range};
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        fails++;
      end else begin
        want = pending_normals.pop_front();
        n_checked++;
        if (got.nx !== want.nx) begin
          $display("%0t: normal_x expected %0d got %0d", $time, want.nx, got.nx);
          fails++;
        end
        if (got.ny !== want.ny) begin
          $display("%0t: normal_y expected %0d got %0d", $time, want.ny, got.ny);
          fails++;
        end
        if (got.nz !== want.nz) begin
          $display("%0t: normal_z expected %0d got %0d", $time, want.nz, got.nz);
          fails++;
        end
        if (got.oor !== want.oor) begin
          $display("%0t: out_of_range expected %0d got %0d", $time, want.oor, got.oor);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default 100 x 100 grid: corners, edges, centre, just outside and the far corner of the store.
  task automatic test_reset_grid();
    query_vertex(0, 0);
    query_vertex(99, 99);
    query_vertex(0, 99);
    query_vertex(99, 0);
    query_vertex(50, 50);
    query_vertex(100, 5);
    query_vertex(5, 100);
    query_vertex(127, 127);
  endtask

  // Register extremes and steepest height steps.
  task automatic test_extremes();
    write_reg(hvn_pkg::REG_GRID_ROWS, 0);      // saturates to 2
    write_reg(hvn_pkg::REG_GRID_COLUMNS, 1);   // saturates to 2
    send_item(hvn_pkg::OP_LOAD, 0, 0, 16'sh7fff);
    send_item(hvn_pkg::OP_LOAD, 1, 0, -16'sh8000);
    send_item(hvn_pkg::OP_LOAD, 0, 1, -16'sh8000);
    send_item(hvn_pkg::OP_LOAD, 1, 1, 16'sh7fff);
    query_vertex(0, 0);
    query_vertex(1, 1);
    query_vertex(2, 0);
    write_reg(hvn_pkg::REG_GRID_ROWS, 255);    // saturates to 128
    write_reg(hvn_pkg::REG_GRID_COLUMNS, 128);
    send_item(hvn_pkg::OP_LOAD, 127, 127, -16'sh8000);
    send_item(hvn_pkg::OP_LOAD, 126, 126, 16'sh7fff);
    query_vertex(127, 127);
    query_vertex(126, 127);
    query_vertex(0, 127);
    query_vertex(127, 0);
  endtask

  // Hold the result side off for a long stretch while queries keep coming.
  task automatic test_backpressure();
    write_reg(hvn_pkg::REG_GRID_ROWS, 8);
    write_reg(hvn_pkg::REG_GRID_COLUMNS, 8);
    hold_left = 3000;
    for (int k = 0; k < 12; k++) query_vertex($urandom_range(0, 9), $urandom_range(0, 9));
  endtask

  // Pause the sender until every prediction has been matched.
  task automatic test_drain_pause();
    query_vertex(3, 3);
    wait_drained();
    query_vertex(7, 7);
  endtask

  // Random phases: mostly fill-and-query sequences, with stray loads as noise.
  // The count is in transactions, neighbour loads included.
  task automatic test_random(int count);
    int sent, steps, base, span_r, span_c, pick;
    base  = n_loads + n_queries;
    sent  = 0;
    steps = 0;
    while (sent < count) begin
      if (steps % 100 == 0) begin
        pick = $urandom_range(0, 4);
        write_reg(hvn_pkg::REG_GRID_ROWS, (pick == 0) ? $urandom_range(0, 255) :
                                          (pick == 1) ? 128 : $urandom_range(2, 16));
        write_reg(hvn_pkg::REG_GRID_COLUMNS, (pick == 0) ? $urandom_range(0, 255) :
                                             (pick == 1) ? 128 : $urandom_range(2, 16));
      end
      if (count - sent < 250) quiet = 1'b1;
      span_r = (rows_cfg > 125) ? 127 : rows_cfg + 2;
      span_c = (cols_cfg > 125) ? 127 : cols_cfg + 2;
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        if ($urandom_range(0, 9) == 0) query_vertex($urandom_range(0, 127), $urandom_range(0, 127));
        else query_vertex($urandom_range(0, span_r), $urandom_range(0, span_c));
      end else if (pick < 13) begin
        send_item(hvn_pkg::OP_LOAD, $urandom_range(0, 127), $urandom_range(0, 127),
                  16'($urandom));
      end else begin
        send_item(hvn_pkg::OP_LOAD, $urandom_range(0, span_r), $urandom_range(0, span_c),
                  16'($urandom));
      end
      steps++;
      sent = n_loads + n_queries - base;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = hvn_pkg::OP_LOAD;
    in_ch.row = '0;
    in_ch.column = '0;
    in_ch.height = '0;
    cfg_we = 1'b0;
    cfg_index = hvn_pkg::REG_GRID_ROWS;
    cfg_data = '0;
    fails = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_left = 0;
    rows_cfg = hvn_pkg::GRID_RESET;
    cols_cfg = hvn_pkg::GRID_RESET;
    n_loads = 0; n_queries = 0; n_oor = 0; n_checked = 0;
    for (int k = 0; k < DEPTH; k++) begin
      shadow_h[k] = '0;
      loaded[k] = 1'b0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_grid();
    test_extremes();
    test_backpressure();
    test_drain_pause();
    test_random(1450);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d loads and %0d queries (%0d outside the grid), %0d results checked",
             n_loads, n_queries, n_oor, n_checked);
    $display("grid sizes from saturated minimum to saturated maximum, with stalls on both sides");
    if (fails == 0 && pending_normals.size() == 0) begin
      $display("heightfield_vertex_normals_top_tb OK");
    end else begin
      $display("heightfield_vertex_normals_top_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
